// ===== src/gdmc_pkg.sv =====
package gdmc_pkg;

  // Command codes carried in the request tuser
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_SPEED    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POSITION = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

  // Configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_SPEED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_LIMIT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEAR_MARGIN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CAP     = 3'd5;

  // Fixed register widths
  localparam int MARGIN_BITS = 16;
  localparam int GAIN_BITS   = 16;
  localparam int CAP_BITS    = 19;

  // Register reset values
  localparam int RST_OPEN_LIMIT  = 40000;
  localparam int RST_CLOSE_LIMIT = 0;
  localparam int RST_NEAR_MARGIN = 2000;
  localparam int RST_PROP_GAIN   = 1280;
  localparam int RST_SPEED_CAP   = 500000;

  // Result flags, in_position_mode in bit 0
  typedef struct packed {
    logic target_reached;
    logic in_position_mode;
  } out_flags_t;

endpackage

// ===== src/gdmc_cfg_regs.sv =====
module gdmc_cfg_regs
  import gdmc_pkg::*;
#(
  parameter int POS_BITS   = 17,
  parameter int SPEED_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [CFG_INDEX_W-1:0]        wr_index,
  input  logic [CFG_DATA_W-1:0]         wr_data,
  output logic signed [SPEED_BITS-1:0]  default_speed,
  output logic signed [POS_BITS-1:0]    open_limit,
  output logic signed [POS_BITS-1:0]    close_limit,
  output logic [MARGIN_BITS-1:0]        near_margin,
  output logic [GAIN_BITS-1:0]          prop_gain,
  output logic [CAP_BITS-1:0]           speed_cap
);

  // Decode a write request; indexes beyond the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      default_speed <= '0;
      open_limit    <= POS_BITS'(RST_OPEN_LIMIT);
      close_limit   <= POS_BITS'(RST_CLOSE_LIMIT);
      near_margin   <= MARGIN_BITS'(RST_NEAR_MARGIN);
      prop_gain     <= GAIN_BITS'(RST_PROP_GAIN);
      speed_cap     <= CAP_BITS'(RST_SPEED_CAP);
    end else if (wr_en) begin
      case (wr_index)
        REG_DEFAULT_SPEED: default_speed <= wr_data[SPEED_BITS-1:0];
        REG_OPEN_LIMIT:    open_limit    <= wr_data[POS_BITS-1:0];
        REG_CLOSE_LIMIT:   close_limit   <= wr_data[POS_BITS-1:0];
        REG_NEAR_MARGIN:   near_margin   <= wr_data[MARGIN_BITS-1:0];
        REG_PROP_GAIN:     prop_gain     <= wr_data[GAIN_BITS-1:0];
        REG_SPEED_CAP:     speed_cap     <= wr_data[CAP_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/gdmc_step.sv =====
module gdmc_step
  import gdmc_pkg::*;
#(
  parameter int POS_BITS       = 17,
  parameter int SPEED_BITS     = 20,
  parameter int GAIN_FRAC_BITS = 8
) (
  // Current request
  input  logic [CMD_W-1:0]              cmd,
  input  logic signed [SPEED_BITS-1:0]  request_value,
  input  logic signed [POS_BITS-1:0]    finger_one_pos,
  input  logic signed [POS_BITS-1:0]    finger_two_pos,
  // Configuration
  input  logic signed [SPEED_BITS-1:0]  default_speed,
  input  logic signed [POS_BITS-1:0]    open_limit,
  input  logic signed [POS_BITS-1:0]    close_limit,
  input  logic [MARGIN_BITS-1:0]        near_margin,
  input  logic [GAIN_BITS-1:0]          prop_gain,
  input  logic [CAP_BITS-1:0]           speed_cap,
  // Current state
  input  logic                          mode_is_position,
  input  logic                          moving_closed,
  input  logic [SPEED_BITS-1:0]         speed_magnitude,
  input  logic signed [SPEED_BITS-1:0]  signed_drive,
  input  logic signed [POS_BITS-1:0]    target_opening,
  input  logic signed [POS_BITS-1:0]    first_finger,
  input  logic signed [POS_BITS-1:0]    second_finger,
  // Next state
  output logic                          mode_is_position_next,
  output logic                          moving_closed_next,
  output logic [SPEED_BITS-1:0]         speed_magnitude_next,
  output logic signed [SPEED_BITS-1:0]  signed_drive_next,
  output logic signed [POS_BITS-1:0]    target_opening_next,
  output logic signed [POS_BITS-1:0]    first_finger_next,
  output logic signed [POS_BITS-1:0]    second_finger_next,
  // Result
  output logic                          emit,
  output logic signed [SPEED_BITS-1:0]  drive_speed,
  output out_flags_t                    flags
);

  localparam int SUM_W  = POS_BITS + 1;
  localparam int CMP_W  = ((SPEED_BITS > POS_BITS) ? SPEED_BITS : POS_BITS) + 1;
  localparam int LIM_W  = ((POS_BITS > MARGIN_BITS) ? POS_BITS : MARGIN_BITS) + 2;
  localparam int PROD_W = SUM_W + GAIN_BITS + 1;
  localparam int DRV_W  = ((PROD_W > SPEED_BITS) ? PROD_W : SPEED_BITS) + 2;
  localparam int MAG_W  = (SUM_W > MARGIN_BITS) ? SUM_W : MARGIN_BITS;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS-1){1'b1}}};
  localparam logic [SPEED_BITS-1:0] SPEED_MIN = {1'b1, {(SPEED_BITS-1){1'b0}}};

  logic signed [SUM_W-1:0]      sample_sum;
  logic signed [POS_BITS-1:0]   sample_avg;
  logic signed [SUM_W-1:0]      stored_sum;
  logic signed [POS_BITS-1:0]   stored_avg;
  logic [SPEED_BITS-1:0]        default_neg;
  logic [SPEED_BITS-1:0]        default_abs;
  logic [SPEED_BITS-1:0]        magnitude;
  logic signed [CMP_W-1:0]      req_x;
  logic signed [CMP_W-1:0]      open_x;
  logic signed [CMP_W-1:0]      close_x;
  logic signed [LIM_W-1:0]      margin_l;
  logic signed [LIM_W-1:0]      avg_l;
  logic signed [LIM_W-1:0]      open_near;
  logic signed [LIM_W-1:0]      close_near;
  logic signed [SUM_W-1:0]      pos_err;
  logic [SUM_W-1:0]             err_mag;
  logic signed [GAIN_BITS:0]    gain_s;
  logic signed [PROD_W-1:0]     product;
  logic signed [PROD_W-1:0]     product_sh;
  logic signed [DRV_W-1:0]      drv_x;
  logic signed [DRV_W-1:0]      cap_x;
  logic signed [DRV_W-1:0]      capped;
  logic signed [DRV_W-1:0]      smax_x;
  logic signed [DRV_W-1:0]      smin_x;
  logic signed [DRV_W-1:0]      limited;
  logic                         reached;

  // Finger averages, floor of the half sum
  assign sample_sum = SUM_W'(finger_one_pos) + SUM_W'(finger_two_pos);
  assign sample_avg = POS_BITS'(sample_sum >>> 1);
  assign stored_sum = SUM_W'(first_finger) + SUM_W'(second_finger);
  assign stored_avg = POS_BITS'(stored_sum >>> 1);

  // Speed magnitude: positive request or saturated |default_speed|
  assign default_neg = -default_speed;
  always_comb begin
    if (!default_speed[SPEED_BITS-1]) begin
      default_abs = default_speed;
    end else if (default_neg[SPEED_BITS-1]) begin
      default_abs = SPEED_MAX;
    end else begin
      default_abs = default_neg;
    end
  end
  assign magnitude = (!request_value[SPEED_BITS-1] && (request_value != '0)) ?
                     request_value : default_abs;

  // Target clamp operands
  assign req_x   = CMP_W'(request_value);
  assign open_x  = CMP_W'(open_limit);
  assign close_x = CMP_W'(close_limit);

  // Reversal thresholds
  assign margin_l   = LIM_W'($signed({1'b0, near_margin}));
  assign avg_l      = LIM_W'(sample_avg);
  assign open_near  = LIM_W'(open_limit) - margin_l;
  assign close_near = LIM_W'(close_limit) + margin_l;

  // Proportional drive, Q8.8 gain with floor on the dropped fraction
  assign pos_err    = SUM_W'(target_opening) - SUM_W'(stored_avg);
  assign err_mag    = pos_err[SUM_W-1] ? SUM_W'(-pos_err) : SUM_W'(pos_err);
  assign reached    = MAG_W'(err_mag) < MAG_W'(near_margin);
  assign gain_s     = $signed({1'b0, prop_gain});
  assign product    = PROD_W'(pos_err) * PROD_W'(gain_s);
  assign product_sh = product >>> GAIN_FRAC_BITS;

  // Saturate to the cap, then to the speed range
  assign drv_x  = DRV_W'(product_sh);
  assign cap_x  = DRV_W'($signed({1'b0, speed_cap}));
  assign smax_x = DRV_W'($signed(SPEED_MAX));
  assign smin_x = DRV_W'($signed(SPEED_MIN));
  always_comb begin
    if (drv_x > cap_x) begin
      capped = cap_x;
    end else if (drv_x < -cap_x) begin
      capped = -cap_x;
    end else begin
      capped = drv_x;
    end
    if (capped > smax_x) begin
      limited = smax_x;
    end else if (capped < smin_x) begin
      limited = smin_x;
    end else begin
      limited = capped;
    end
  end

  // Apply the request to the state and form the result
  always_comb begin
    mode_is_position_next = mode_is_position;
    moving_closed_next    = moving_closed;
    speed_magnitude_next  = speed_magnitude;
    signed_drive_next     = signed_drive;
    target_opening_next   = target_opening;
    first_finger_next     = first_finger;
    second_finger_next    = second_finger;
    emit                  = 1'b0;
    drive_speed           = signed_drive;
    flags                 = '0;
    case (cmd)
      CMD_SPEED: begin
        mode_is_position_next = 1'b0;
        speed_magnitude_next  = magnitude;
        signed_drive_next     = moving_closed ? -magnitude : magnitude;
      end
      CMD_POSITION: begin
        mode_is_position_next = 1'b1;
        if (req_x > open_x) begin
          target_opening_next = open_limit;
        end else if (req_x < close_x) begin
          target_opening_next = close_limit;
        end else begin
          target_opening_next = POS_BITS'(request_value);
        end
      end
      CMD_SAMPLE: begin
        first_finger_next  = finger_one_pos;
        second_finger_next = finger_two_pos;
        if (!mode_is_position) begin
          if (!moving_closed && (avg_l >= open_near)) begin
            moving_closed_next = 1'b1;
            signed_drive_next  = -speed_magnitude;
          end else if (moving_closed && (avg_l <= close_near)) begin
            moving_closed_next = 1'b0;
            signed_drive_next  = speed_magnitude;
          end
        end
      end
      CMD_TICK: begin
        emit = 1'b1;
        if (mode_is_position) begin
          drive_speed            = reached ? '0 : SPEED_BITS'(limited);
          flags.in_position_mode = 1'b1;
          flags.target_reached   = reached;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/gripper_dual_mode_drive_controller_core.sv =====
// Gripper drive controller with a velocity mode and a proportional position
// mode. Requests arrive on the s_ stream with the command in s_tuser (speed
// request, position request, finger sample, tick); only a tick produces a
// result on the m_ stream. Each request is held in the input register and
// passes once through the update logic; a new request is taken every cycle
// and the only stall comes from a tick whose result register is still full.
// The proportional multiply, the saturation and the deadband compare all
// sit in that one pass. Registers on the cfg port are to be written by the
// user only while the block is idle; the block does not enforce this.
// Writes to indexes beyond the speed cap are dropped.
module gripper_dual_mode_drive_controller_core
  import gdmc_pkg::*;
#(
  parameter int POS_BITS       = 17,
  parameter int SPEED_BITS     = 20,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // Request stream
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // request_value, finger_one_pos, finger_two_pos
  input  logic [((SPEED_BITS+2*POS_BITS+7)/8)*8-1:0] s_tdata,
  // cmd
  input  logic [CMD_W-1:0]                          s_tuser,
  // Result stream
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // drive_speed
  output logic [((SPEED_BITS+7)/8)*8-1:0]           m_tdata,
  // in_position_mode, target_reached
  output logic [1:0]                                m_tuser,
  // Configuration writes
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_data
);

  localparam int OUT_W = ((SPEED_BITS + 7) / 8) * 8;

  logic signed [SPEED_BITS-1:0] default_speed;
  logic signed [POS_BITS-1:0]   open_limit;
  logic signed [POS_BITS-1:0]   close_limit;
  logic [MARGIN_BITS-1:0]       near_margin;
  logic [GAIN_BITS-1:0]         prop_gain;
  logic [CAP_BITS-1:0]          speed_cap;

  logic                         in_valid;
  logic [CMD_W-1:0]             in_cmd;
  logic signed [SPEED_BITS-1:0] in_req;
  logic signed [POS_BITS-1:0]   in_f1;
  logic signed [POS_BITS-1:0]   in_f2;

  logic                         mode_is_position;
  logic                         moving_closed;
  logic [SPEED_BITS-1:0]        speed_magnitude;
  logic signed [SPEED_BITS-1:0] signed_drive;
  logic signed [POS_BITS-1:0]   target_opening;
  logic signed [POS_BITS-1:0]   first_finger;
  logic signed [POS_BITS-1:0]   second_finger;

  logic                         mode_is_position_next;
  logic                         moving_closed_next;
  logic [SPEED_BITS-1:0]        speed_magnitude_next;
  logic signed [SPEED_BITS-1:0] signed_drive_next;
  logic signed [POS_BITS-1:0]   target_opening_next;
  logic signed [POS_BITS-1:0]   first_finger_next;
  logic signed [POS_BITS-1:0]   second_finger_next;

  logic                         emit;
  logic signed [SPEED_BITS-1:0] step_drive;
  out_flags_t                   step_flags;
  logic                         advance;
  logic signed [SPEED_BITS-1:0] out_drive;
  out_flags_t                   out_flags;

  assign cfg_ready = 1'b1;

  gdmc_cfg_regs #(
    .POS_BITS   (POS_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_valid & cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .default_speed (default_speed),
    .open_limit    (open_limit),
    .close_limit   (close_limit),
    .near_margin   (near_margin),
    .prop_gain     (prop_gain),
    .speed_cap     (speed_cap)
  );

  // Advance the held request unless it is a tick blocked by a full result
  assign advance  = in_valid && ((in_cmd != CMD_TICK) || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd <= s_tuser;
      in_req <= s_tdata[SPEED_BITS-1:0];
      in_f1  <= s_tdata[SPEED_BITS+POS_BITS-1:SPEED_BITS];
      in_f2  <= s_tdata[SPEED_BITS+2*POS_BITS-1:SPEED_BITS+POS_BITS];
    end
  end

  gdmc_step #(
    .POS_BITS       (POS_BITS),
    .SPEED_BITS     (SPEED_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_step (
    .cmd                   (in_cmd),
    .request_value         (in_req),
    .finger_one_pos        (in_f1),
    .finger_two_pos        (in_f2),
    .default_speed         (default_speed),
    .open_limit            (open_limit),
    .close_limit           (close_limit),
    .near_margin           (near_margin),
    .prop_gain             (prop_gain),
    .speed_cap             (speed_cap),
    .mode_is_position      (mode_is_position),
    .moving_closed         (moving_closed),
    .speed_magnitude       (speed_magnitude),
    .signed_drive          (signed_drive),
    .target_opening        (target_opening),
    .first_finger          (first_finger),
    .second_finger         (second_finger),
    .mode_is_position_next (mode_is_position_next),
    .moving_closed_next    (moving_closed_next),
    .speed_magnitude_next  (speed_magnitude_next),
    .signed_drive_next     (signed_drive_next),
    .target_opening_next   (target_opening_next),
    .first_finger_next     (first_finger_next),
    .second_finger_next    (second_finger_next),
    .emit                  (emit),
    .drive_speed           (step_drive),
    .flags                 (step_flags)
  );

  // Controller state, updated as each request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_is_position <= 1'b0;
      moving_closed    <= 1'b0;
      speed_magnitude  <= '0;
      signed_drive     <= '0;
      target_opening   <= '0;
      first_finger     <= '0;
      second_finger    <= '0;
    end else if (advance) begin
      mode_is_position <= mode_is_position_next;
      moving_closed    <= moving_closed_next;
      speed_magnitude  <= speed_magnitude_next;
      signed_drive     <= signed_drive_next;
      target_opening   <= target_opening_next;
      first_finger     <= first_finger_next;
      second_finger    <= second_finger_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_drive <= step_drive;
      out_flags <= step_flags;
    end
  end

  assign m_tdata = OUT_W'($unsigned(out_drive));
  assign m_tuser = out_flags;

endmodule

// ===== dv/gripper_dual_mode_drive_controller_core_tb.sv =====
`timescale 1ns / 100ps

module gripper_dual_mode_drive_controller_core_tb;
  import gdmc_pkg::*;

  localparam int POS_W      = 17;
  localparam int SPEED_W    = 20;
  localparam int FRAC_W     = 8;
  localparam int REQ_DATA_W = ((SPEED_W + 2*POS_W + 7)/8)*8;
  localparam int RES_DATA_W = ((SPEED_W + 7)/8)*8;
  localparam longint SPEED_MAX = (longint'(1) << (SPEED_W-1)) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  // Indexes past the register map; writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [SPEED_W-1:0] drive;
    logic                      pos_flag;
    logic                      reached;
  } drive_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // request_value, finger_one_pos, finger_two_pos (from bit 0 up)
  logic [REQ_DATA_W-1:0] s_tdata;
  // cmd
  logic [CMD_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  // drive_speed
  logic [RES_DATA_W-1:0] m_tdata;
  // in_position_mode, target_reached (from bit 0 up)
  logic [1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gripper_dual_mode_drive_controller_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Controller copy: registers
  logic signed [SPEED_W-1:0] dflt_speed = '0;
  logic signed [POS_W-1:0]   open_lim   = POS_W'(RST_OPEN_LIMIT);
  logic signed [POS_W-1:0]   close_lim  = POS_W'(RST_CLOSE_LIMIT);
  logic [MARGIN_BITS-1:0]    margin     = MARGIN_BITS'(RST_NEAR_MARGIN);
  logic [GAIN_BITS-1:0]      gain       = GAIN_BITS'(RST_PROP_GAIN);
  logic [CAP_BITS-1:0]       cap        = CAP_BITS'(RST_SPEED_CAP);

  // Controller copy: state
  logic                      pos_mode   = 1'b0;
  logic                      closing    = 1'b0;
  logic [SPEED_W-1:0]        speed_mag  = '0;
  logic signed [SPEED_W-1:0] drive_hold = '0;
  logic signed [POS_W-1:0]   target     = '0;
  logic signed [POS_W-1:0]   finger_a   = '0;
  logic signed [POS_W-1:0]   finger_b   = '0;

  drive_result_t pending_drives[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  bursty = 1'b1;
  int  hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint finger_mean();
    return (longint'(finger_a) + longint'(finger_b)) >>> 1;
  endfunction

  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DEFAULT_SPEED: dflt_speed = val[SPEED_W-1:0];
      REG_OPEN_LIMIT:    open_lim   = val[POS_W-1:0];
      REG_CLOSE_LIMIT:   close_lim  = val[POS_W-1:0];
      REG_NEAR_MARGIN:   margin     = val[MARGIN_BITS-1:0];
      REG_PROP_GAIN:     gain       = val[GAIN_BITS-1:0];
      REG_SPEED_CAP:     cap        = val[CAP_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advance the controller copy by one request; queue the drive a tick makes
  function automatic void track_request(logic [CMD_W-1:0] cmd,
                                        logic [REQ_DATA_W-1:0] data);
    logic signed [SPEED_W-1:0] req;
    longint mag;
    longint avg;
    longint err;
    longint drv;
    drive_result_t res;
    req = data[SPEED_W-1:0];
    case (cmd)
      CMD_SPEED: begin
        pos_mode = 1'b0;
        if (req > 0) begin
          mag = req;
        end else begin
          mag = (dflt_speed < 0) ? -longint'(dflt_speed) : longint'(dflt_speed);
          if (mag > SPEED_MAX) mag = SPEED_MAX;
        end
        speed_mag  = mag[SPEED_W-1:0];
        drive_hold = SPEED_W'(closing ? -mag : mag);
      end
      CMD_POSITION: begin
        pos_mode = 1'b1;
        if (req > open_lim)       target = open_lim;
        else if (req < close_lim) target = close_lim;
        else                      target = req[POS_W-1:0];
      end
      CMD_SAMPLE: begin
        finger_a = data[SPEED_W +: POS_W];
        finger_b = data[SPEED_W+POS_W +: POS_W];
        avg = finger_mean();
        // Reverse near a limit, velocity mode only
        if (!pos_mode) begin
          if (!closing && avg >= longint'(open_lim) - longint'(margin)) begin
            closing    = 1'b1;
            drive_hold = SPEED_W'(-longint'(speed_mag));
          end else if (closing && avg <= longint'(close_lim) + longint'(margin)) begin
            closing    = 1'b0;
            drive_hold = speed_mag;
          end
        end
      end
      CMD_TICK: begin
        if (!pos_mode) begin
          res.drive    = drive_hold;
          res.pos_flag = 1'b0;
          res.reached  = 1'b0;
        end else begin
          err = longint'(target) - finger_mean();
          drv = (longint'(gain) * err) >>> FRAC_W;
          if (drv > longint'(cap))       drv = cap;
          else if (drv < -longint'(cap)) drv = -longint'(cap);
          if (drv > SPEED_MAX)           drv = SPEED_MAX;
          else if (drv < -SPEED_MAX - 1) drv = -SPEED_MAX - 1;
          res.reached = ((err < 0) ? -err : err) < longint'(margin);
          if (res.reached) drv = 0;
          res.drive    = drv[SPEED_W-1:0];
          res.pos_flag = 1'b1;
        end
        pending_drives.insert(pending_drives.size(), res);
      end
      default: ;
    endcase
  endfunction

  // Follow every accepted register write and request
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
    if (!rst && s_tvalid && s_tready) track_request(s_tuser, s_tdata);
  end

  // Compare each drive result with the oldest prediction
  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drives.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected drive result: drive %0d flags %b",
                   $signed(m_tdata[SPEED_W-1:0]), m_tuser);
      end else begin
        want = pending_drives.pop_front();
        if (m_tdata[SPEED_W-1:0] !== want.drive || m_tuser[0] !== want.pos_flag ||
            m_tuser[1] !== want.reached) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("drive mismatch: expected drive %0d pos %b reached %b, got %0d %b %b",
                     want.drive, want.pos_flag, want.reached,
                     $signed(m_tdata[SPEED_W-1:0]), m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

  // Result side: long hold-offs on demand, short random stalls otherwise
  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one request; leave valid high on return unless a gap was taken
  task automatic send_request(input logic [CMD_W-1:0] cmd, input longint value,
                              input longint f1, input longint f2);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, f2[POS_W-1:0], f1[POS_W-1:0], value[SPEED_W-1:0]};
    do @(posedge clk); while (!s_tready);
    if (bursty && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted drive has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers plus the two unmapped indexes, block idle
  task automatic load_settings(input longint dflt, input longint open_um,
                               input longint close_um, input longint marg,
                               input longint gn, input longint cp);
    logic [CFG_INDEX_W-1:0] idx [8];
    longint val [8];
    idx = '{REG_DEFAULT_SPEED, REG_OPEN_LIMIT, REG_SPARE_LO, REG_CLOSE_LIMIT,
            REG_NEAR_MARGIN, REG_PROP_GAIN, REG_SPARE_HI, REG_SPEED_CAP};
    val = '{dflt, open_um, longint'($urandom()), close_um, marg, gn,
            longint'($urandom()), cp};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i][CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random traffic aimed at the limits, the deadband and full field ranges
  task automatic send_mixed(input int count);
    int pick;
    longint v;
    longint rim;
    longint d;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        case ($urandom_range(0, 3))
          0:       v = -longint'($urandom_range(0, 524288));
          1:       v = $urandom();
          default: v = $urandom_range(1, 524287);
        endcase
        send_request(CMD_SPEED, v, $urandom(), $urandom());
      end else if (pick < 28) begin
        case ($urandom_range(0, 3))
          0:       v = $urandom();
          1:       v = longint'($urandom_range(0, 140000)) - 70000;
          default: v = finger_mean() + longint'($urandom_range(0, 2*margin + 2))
                       - longint'(margin) - 1;
        endcase
        send_request(CMD_POSITION, v, $urandom(), $urandom());
      end else if (pick < 62) begin
        case ($urandom_range(0, 4))
          0:       rim = longint'($urandom());
          1:       rim = longint'(target) + longint'($urandom_range(0, 8000)) - 4000;
          2:       rim = longint'(close_lim) + longint'(margin);
          default: rim = longint'(open_lim) - longint'(margin);
        endcase
        rim = rim + longint'($urandom_range(0, 64)) - 32;
        d = $urandom_range(0, 500);
        if ($urandom_range(0, 5) == 0)
          send_request(CMD_SAMPLE, $urandom(), $urandom(), $urandom());
        else
          send_request(CMD_SAMPLE, $urandom(), rim + d,
                       rim - d - longint'($urandom_range(0, 1)));
      end else begin
        send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  // Ticks before any sample, the first also before any command; fingers read as zero
  task automatic test_power_on_state();
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_POSITION, 30000, $urandom(), $urandom());
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
  endtask

  // Field extremes, every command, reversal and mode corner cases
  task automatic test_command_extremes();
    // Samples in position mode leave the direction alone
    send_request(CMD_SAMPLE, $urandom(), 65535, 65535);
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_SPEED, 524287, $urandom(), $urandom());
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    // Reverse at the open limit, then at the close limit
    send_request(CMD_SAMPLE, $urandom(), 40000, 40000);
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_SPEED, 0, $urandom(), $urandom());
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_SPEED, -524288, $urandom(), $urandom());
    send_request(CMD_SAMPLE, $urandom(), -65536, -65536);
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_SPEED, 1, $urandom(), $urandom());
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    // Clamp to both limits, deadband hit with an odd finger sum
    send_request(CMD_POSITION, 524287, $urandom(), $urandom());
    send_request(CMD_SAMPLE, $urandom(), 39000, 39001);
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_POSITION, -524288, $urandom(), $urandom());
    send_request(CMD_SAMPLE, $urandom(), 65535, -65536);
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
    send_request(CMD_SAMPLE, $urandom(), -65536, -65535);
    send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
  endtask

  // Several register settings, extremes and crossed limits among them
  task automatic test_register_sweep();
    longint dflt [7];
    longint open_um [7];
    longint close_um [7];
    longint marg [7];
    longint gn [7];
    longint cp [7];
    dflt     = '{-524288, 524287, -1000, 0, 0, 0, 0};
    open_um  = '{40000, 65535, 1000, -65536, 0, 0, 0};
    close_um = '{0, -65536, 5000, 65535, 0, 0, 0};
    marg     = '{2000, 0, 300, 65535, 0, 0, 0};
    gn       = '{1280, 65535, 256, 0, 0, 0, 0};
    cp       = '{500000, 524287, 0, 1, 0, 0, 0};
    for (int i = 0; i < 7; i++) begin
      drain_results();
      if (i >= 4)
        load_settings($urandom(), $urandom(), $urandom(), $urandom_range(0, 6000),
                      $urandom(), $urandom());
      else
        load_settings(dflt[i], open_um[i], close_um[i], marg[i], gn[i], cp[i]);
      send_request(CMD_SPEED, 0, $urandom(), $urandom());
      send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
      send_request(CMD_POSITION, 70000, $urandom(), $urandom());
      send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
      send_request(CMD_POSITION, -70000, $urandom(), $urandom());
      send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
      send_mixed(50);
    end
    drain_results();
    load_settings(0, RST_OPEN_LIMIT, RST_CLOSE_LIMIT, RST_NEAR_MARGIN,
                  RST_PROP_GAIN, RST_SPEED_CAP);
  endtask

  // Hold the result side off long enough to stall the request side
  task automatic test_result_backpressure();
    bursty = 1'b0;
    hold_request = 150;
    repeat (6) begin
      send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
      send_request(CMD_SAMPLE, $urandom(), $urandom(), $urandom());
      send_request(CMD_TICK, $urandom(), $urandom(), $urandom());
      send_request(CMD_POSITION, $urandom(), $urandom(), $urandom());
    end
    bursty = 1'b1;
    drain_results();
  endtask

  task automatic test_random_mix();
    send_mixed(150);
    drain_results();
    load_settings($urandom(), 30000, -30000, 1500, 900, 200000);
    send_mixed(40);
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    drain_results();
    bursty = 1'b0;
    send_mixed(60);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DEFAULT_SPEED;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on_state();
    test_command_extremes();
    test_register_sweep();
    test_result_backpressure();
    test_random_mix();
    test_steady_stream();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_drives.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/gdmc_pkg.sv
src/gdmc_cfg_regs.sv
src/gdmc_step.sv
src/gripper_dual_mode_drive_controller_core.sv
dv/gripper_dual_mode_drive_controller_core_tb.sv
